FILE: rtl/core/mirror_health_table_assert.svh
// assertion macros shared by the health table rtl
`ifndef MIRROR_HEALTH_TABLE_ASSERT_SVH
`define MIRROR_HEALTH_TABLE_ASSERT_SVH

// consequence checked in the same cycle as the antecedent
`define MHT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the cycle after the antecedent
`define MHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mht_pkg.sv
// shared types and constants of the server health table
package mht_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int KEY_W      = 32;
    localparam int TIME_W     = 32;
    localparam int TALLY_W    = 32;
    localparam int LEVEL_W    = 8;
    localparam int VERDICT_W  = 2;
    // wide enough for a signed difference of two signed 33-bit values
    localparam int ALU_W      = TIME_W + 2;

    localparam logic [TIME_W-1:0]  IGNORE_SECONDS_RST   = TIME_W'(3 * 86400);
    localparam logic [TIME_W-1:0]  OUTDATED_SECONDS_RST = TIME_W'(4 * 3600);
    localparam logic [TALLY_W-1:0] FAIL_LIMIT           = TALLY_W'(3);
    localparam logic [LEVEL_W-1:0] LEVEL_GAP            = LEVEL_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE           = 3'd0,
        CFG_LOCAL_LEVEL      = 3'd1,
        CFG_DATABASE_LEVEL   = 3'd2,
        CFG_IGNORE_SECONDS   = 3'd3,
        CFG_OUTDATED_SECONDS = 3'd4
    } t_cfg_index;

    typedef enum logic {
        CMD_CHECK  = 1'b0,
        CMD_RECORD = 1'b1
    } t_command;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_USABLE   = 2'd0,
        VERDICT_IGNORED  = 2'd1,
        VERDICT_OUTDATED = 2'd2
    } t_verdict;

    typedef struct packed {
        logic                enable;
        logic [LEVEL_W-1:0]  local_level;
        logic [LEVEL_W-1:0]  database_level;
        logic [TIME_W-1:0]   ignore_seconds;
        logic [TIME_W-1:0]   outdated_seconds;
    } t_cfg;

    typedef struct packed {
        logic                command;
        logic [KEY_W-1:0]    address;
        logic [TIME_W-1:0]   now_seconds;
        logic                broken;
    } t_in_word;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic                 table_full;
    } t_result;

    typedef struct packed {
        logic                ignored;
        logic [TALLY_W-1:0]  failures;
        logic [TALLY_W-1:0]  successes;
        logic [TIME_W-1:0]   access_time;
    } t_entry;

    typedef struct packed {
        logic                    eq;
        logic                    lt;
        logic signed [ALU_W-1:0] diff;
    } t_alu_res;

endpackage

FILE: rtl/core/mht_if.sv
// valid/ready channels carrying request and result words
interface mht_in_if;
    import mht_pkg::*;

    logic                valid;
    logic                ready;
    logic                command;
    logic [KEY_W-1:0]    address;
    logic [TIME_W-1:0]   now_seconds;
    logic                broken;

    modport source (output valid, command, address, now_seconds, broken, input ready);
    modport sink   (input valid, command, address, now_seconds, broken, output ready);
endinterface

interface mht_out_if;
    import mht_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic                 table_full;

    modport source (output valid, verdict, table_full, input ready);
    modport sink   (input valid, verdict, table_full, output ready);
endinterface

FILE: rtl/core/mht_ram.sv
// generic single-write, registered-read ram
module mht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/mht_alu.sv
// shared subtract and compare unit
module mht_alu (
    input  logic signed [mht_pkg::ALU_W-1:0] i_a,
    input  logic signed [mht_pkg::ALU_W-1:0] i_b,
    output mht_pkg::t_alu_res                o_res
);
    import mht_pkg::*;

    logic signed [ALU_W-1:0] diff;

    assign diff       = i_a - i_b;
    assign o_res.diff = diff;
    assign o_res.eq   = (diff == '0);
    assign o_res.lt   = diff[ALU_W-1];
endmodule

FILE: rtl/core/mht_ctrl.sv
// sequencer that scans the table and evaluates, updates or appends one entry
`include "mirror_health_table_assert.svh"

module mht_ctrl #(
    parameter int TABLE_ENTRIES = mht_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mht_pkg::t_cfg     i_cfg,
    input  logic              i_start,
    input  mht_pkg::t_in_word i_word,
    output logic              o_ready,
    output logic              o_done,
    output mht_pkg::t_result  o_res,
    input  logic              i_res_ready
);
    import mht_pkg::*;

    localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int ELAPSED_W = TIME_W + 1;
    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SCAN    = 8'b0000_0010,
        S_ELAPSED = 8'b0000_0100,
        S_WINDOW  = 8'b0000_1000,
        S_RELEASE = 8'b0001_0000,
        S_UPDATE  = 8'b0010_0000,
        S_APPEND  = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    t_state                       r_state, n_state;
    t_in_word                     r_key, n_key;
    logic [CNT_W-1:0]             r_issue, n_issue;
    logic                         r_cmp_valid, n_cmp_valid;
    logic [IDX_W-1:0]             r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]             r_slot, n_slot;
    t_entry                       r_entry, n_entry;
    logic signed [ELAPSED_W-1:0]  r_elapsed, n_elapsed;
    t_result                      r_res, n_res;
    logic [CNT_W-1:0]             r_count, n_count;

    logic [KEY_W-1:0]        key_q;
    t_entry                  entry_q;
    logic                    addr_we;
    logic                    data_we;
    logic [IDX_W-1:0]        waddr;
    logic [IDX_W-1:0]        raddr;
    t_entry                  data_wdata;
    logic signed [ALU_W-1:0] alu_a;
    logic signed [ALU_W-1:0] alu_b;
    t_alu_res                alu_res;
    logic                    old_level;
    logic [TALLY_W-1:0]      fail_new;
    logic [TALLY_W-1:0]      succ_new;

    assign raddr = r_issue[IDX_W-1:0];

    mht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (addr_we),
        .i_waddr (waddr),
        .i_wdata (r_key.address),
        .i_raddr (raddr),
        .o_rdata (key_q)
    );

    mht_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (waddr),
        .i_wdata (data_wdata),
        .i_raddr (raddr),
        .o_rdata (entry_q)
    );

    mht_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // database level more than the gap above the local level (implies nonzero)
    assign old_level = ({1'b0, i_cfg.database_level}) >
                       ({1'b0, i_cfg.local_level} + {1'b0, LEVEL_GAP});

    assign fail_new = (r_key.broken && (r_entry.failures != '1)) ?
                      r_entry.failures + TALLY_W'(1) : r_entry.failures;
    assign succ_new = (!r_key.broken && (r_entry.successes != '1)) ?
                      r_entry.successes + TALLY_W'(1) : r_entry.successes;

    // operand select for the shared unit
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        case (r_state)
            S_SCAN: begin
                alu_a = {2'b00, key_q};
                alu_b = {2'b00, r_key.address};
            end
            S_ELAPSED: begin
                alu_a = {2'b00, r_key.now_seconds};
                alu_b = {2'b00, r_entry.access_time};
            end
            S_WINDOW: begin
                alu_a = {r_elapsed[ELAPSED_W-1], r_elapsed};
                alu_b = {2'b00, i_cfg.outdated_seconds};
            end
            S_RELEASE: begin
                alu_a = {2'b00, i_cfg.ignore_seconds};
                alu_b = {r_elapsed[ELAPSED_W-1], r_elapsed};
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb begin
        data_wdata = r_entry;
        case (r_state)
            S_RELEASE: begin
                data_wdata.ignored = 1'b0;
            end
            S_UPDATE: begin
                data_wdata.access_time = r_key.now_seconds;
                data_wdata.successes   = succ_new;
                data_wdata.failures    = fail_new;
                data_wdata.ignored     = r_key.broken && (fail_new >= FAIL_LIMIT);
            end
            S_APPEND: begin
                data_wdata.access_time = r_key.now_seconds;
                data_wdata.successes   = {{(TALLY_W-1){1'b0}}, !r_key.broken};
                data_wdata.failures    = {{(TALLY_W-1){1'b0}}, r_key.broken};
                data_wdata.ignored     = 1'b0;
            end
            default: begin
                data_wdata = r_entry;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_issue     = r_issue;
        n_cmp_valid = r_cmp_valid;
        n_cmp_idx   = r_cmp_idx;
        n_slot      = r_slot;
        n_entry     = r_entry;
        n_elapsed   = r_elapsed;
        n_res       = r_res;
        n_count     = r_count;
        addr_we     = 1'b0;
        data_we     = 1'b0;
        waddr       = r_slot;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key       = i_word;
                    n_res       = '0;
                    n_issue     = '0;
                    n_cmp_valid = 1'b0;
                    n_state     = i_cfg.enable ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                // read of one entry is issued while the previous one is compared
                if (r_cmp_valid && alu_res.eq) begin
                    n_slot      = r_cmp_idx;
                    n_entry     = entry_q;
                    n_cmp_valid = 1'b0;
                    n_state     = (r_key.command == CMD_RECORD) ? S_UPDATE : S_ELAPSED;
                end else if (r_issue < r_count) begin
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_issue[IDX_W-1:0];
                    n_issue     = r_issue + 1'b1;
                end else begin
                    n_cmp_valid = 1'b0;
                    if (r_key.command == CMD_RECORD) begin
                        if (r_count < COUNT_FULL) begin
                            n_state = S_APPEND;
                        end else begin
                            n_res.table_full = 1'b1;
                            n_state          = S_DONE;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ELAPSED: begin
                n_elapsed = alu_res.diff[ELAPSED_W-1:0];
                n_state   = S_WINDOW;
            end
            S_WINDOW: begin
                if (old_level && alu_res.lt) begin
                    n_res.verdict = VERDICT_OUTDATED;
                    n_state       = S_DONE;
                end else if (r_entry.ignored) begin
                    n_state = S_RELEASE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RELEASE: begin
                // ignore time passed: clear the flag, otherwise keep ignoring
                if (alu_res.lt) begin
                    data_we = 1'b1;
                end else begin
                    n_res.verdict = VERDICT_IGNORED;
                end
                n_state = S_DONE;
            end
            S_UPDATE: begin
                data_we = 1'b1;
                n_state = S_DONE;
            end
            S_APPEND: begin
                addr_we = 1'b1;
                data_we = 1'b1;
                waddr   = r_count[IDX_W-1:0];
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= n_cmp_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_issue   <= n_issue;
        r_cmp_idx <= n_cmp_idx;
        r_slot    <= n_slot;
        r_entry   <= n_entry;
        r_elapsed <= n_elapsed;
        r_res     <= n_res;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE);
    assign o_res   = r_res;

    `MHT_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, r_state == S_APPEND, r_count == $past(r_count) + 1'b1, "entry count did not advance on append")
    `MHT_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, r_state != S_APPEND, $stable(r_count), "entry count changed outside append")
    `MHT_ASSERT_SAME(a_cmp_in_range, i_clk, i_rst_n, (r_state == S_SCAN) && r_cmp_valid, CNT_W'(r_cmp_idx) < r_count, "compared entry lies beyond the filled table")
    `MHT_ASSERT_NEXT(a_done_held, i_clk, i_rst_n, o_done && !i_res_ready, o_done, "result dropped before it was taken")
    `MHT_ASSERT_SAME(a_full_only_full, i_clk, i_rst_n, o_done && o_res.table_full, r_count == COUNT_FULL, "table full reported with room left")

endmodule

FILE: rtl/core/mirror_health_table.sv
// Server health table: keeps up to TABLE_ENTRIES addresses with last-access time,
// success and failure counts and an ignore flag. A check word returns usable,
// ignored or outdated level; a record word stamps and counts, appending unknown
// addresses and flagging table_full when there is no room. One word is handled
// at a time. The address memory is searched one entry per cycle, up to the match
// position, or up to the fill count when the address is absent; with enable low a
// word skips the search and the table. The result sits in an output register, so
// the next word is taken while a result waits. The table memories start undefined
// and need no clearing after reset; only entries below the fill count are ever used.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
module mirror_health_table #(
    parameter int TABLE_ENTRIES = mht_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mht_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mht_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mht_in_if.sink                           i_in,
    mht_out_if.source                        o_out
);
    import mht_pkg::*;

    t_cfg     r_cfg, n_cfg;
    logic     r_out_valid, n_out_valid;
    t_result  r_out, n_out;

    logic     ctrl_ready;
    logic     ctrl_done;
    t_result  ctrl_res;
    logic     res_ready;
    logic     start;
    t_in_word word;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ENABLE:           n_cfg.enable           = i_cfg_data[0];
                CFG_LOCAL_LEVEL:      n_cfg.local_level      = i_cfg_data[LEVEL_W-1:0];
                CFG_DATABASE_LEVEL:   n_cfg.database_level   = i_cfg_data[LEVEL_W-1:0];
                CFG_IGNORE_SECONDS:   n_cfg.ignore_seconds   = i_cfg_data[TIME_W-1:0];
                CFG_OUTDATED_SECONDS: n_cfg.outdated_seconds = i_cfg_data[TIME_W-1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    assign start = i_in.valid && ctrl_ready;
    assign word  = '{command:     i_in.command,
                     address:     i_in.address,
                     now_seconds: i_in.now_seconds,
                     broken:      i_in.broken};

    mht_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (start),
        .i_word      (word),
        .o_ready     (ctrl_ready),
        .o_done      (ctrl_done),
        .o_res       (ctrl_res),
        .i_res_ready (res_ready)
    );

    // output register takes a new result when empty or being drained
    assign res_ready = !r_out_valid || o_out.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (ctrl_done && res_ready) begin
            n_out_valid = 1'b1;
            n_out       = ctrl_res;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable           <= 1'b0;
            r_cfg.local_level      <= '0;
            r_cfg.database_level   <= '0;
            r_cfg.ignore_seconds   <= IGNORE_SECONDS_RST;
            r_cfg.outdated_seconds <= OUTDATED_SECONDS_RST;
            r_out_valid            <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign i_in.ready       = ctrl_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.verdict    = r_out.verdict;
    assign o_out.table_full = r_out.table_full;
endmodule
